[design/tam_pkg.sv]
// shared constants and helpers for the triad attitude matrix block
package tam_pkg;

  localparam int IN_LIM = 30;
  localparam int MAG_W  = 30;
  localparam int ROOT_W = MAG_W + 1;
  localparam int SQ_W   = 2 * MAG_W + 2;
  localparam int ROT_W  = 16;

  function automatic int norm_lat(input int frac);
    return ROOT_W + frac + 8;
  endfunction

endpackage

[design/tam_delay.sv]
// delay line with stall enable for data riding alongside the normalizer
module tam_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[DEPTH-1];

endmodule

[design/tam_norm.sv]
// pipelined vector normalizer: magnitude prescale, bitwise square root, restoring divide
module tam_norm #(
  parameter int VW       = 16,
  parameter int OUT_FRAC = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [2:0][VW-1:0]       vec_i,
  output logic                     valid_o,
  output logic [2:0][OUT_FRAC+1:0] axis_o,
  output logic                     deg_o
);
  import tam_pkg::*;

  localparam int SW = $clog2(VW + 1);
  localparam int QW = OUT_FRAC + 1;
  localparam int DW = MAG_W + QW;

  // abs and or of magnitudes
  logic               v1_q;
  logic [2:0][VW-1:0] m1_d, m1_q;
  logic [2:0]         n1_q;
  logic [VW-1:0]      o1_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m1_d[k] = vec_i[k][VW-1] ? (~vec_i[k] + 1'b1) : vec_i[k];
    end
  end

  // prescale amount
  logic               v2_q, z2_q;
  logic [SW-1:0]      s2_d, s2_q;
  logic [2:0][VW-1:0] m2_q;
  logic [2:0]         n2_q;

  always_comb begin
    s2_d = '0;
    for (int i = MAG_W; i < VW; i++) begin
      if (o1_q[i]) s2_d = SW'(i - MAG_W + 1);
    end
  end

  // shifted magnitudes
  logic                  v3_q, z3_q;
  logic [2:0][MAG_W-1:0] m3_d, m3_q;
  logic [2:0]            n3_q;

  always_comb begin
    logic [VW+MAG_W-1:0] tmp;
    for (int k = 0; k < 3; k++) begin
      tmp     = {{MAG_W{1'b0}}, m2_q[k]} >> s2_q;
      m3_d[k] = tmp[MAG_W-1:0];
    end
  end

  // squares
  logic                    v4_q, z4_q;
  logic [2:0][2*MAG_W-1:0] q4_q;
  logic [2:0][MAG_W-1:0]   m4_q;
  logic [2:0]              n4_q;

  // square root stages
  logic [SQ_W-1:0]       sn_q   [ROOT_W+1];
  logic [SQ_W-1:0]       sr_q   [ROOT_W+1];
  logic [2:0][MAG_W-1:0] sm_q   [ROOT_W+1];
  logic [2:0]            sneg_q [ROOT_W+1];
  logic                  sz_q   [ROOT_W+1];
  logic                  sv_q   [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      sv_q[0]  <= 1'b0;
    end else if (en_i) begin
      v1_q     <= valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
      sv_q[0]  <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= m1_d;
      for (int k = 0; k < 3; k++) n1_q[k] <= vec_i[k][VW-1];
      o1_q <= m1_d[0] | m1_d[1] | m1_d[2];
      s2_q <= s2_d;
      m2_q <= m1_q;
      n2_q <= n1_q;
      z2_q <= (o1_q == '0);
      m3_q <= m3_d;
      n3_q <= n2_q;
      z3_q <= z2_q;
      for (int k = 0; k < 3; k++) q4_q[k] <= m3_q[k] * m3_q[k];
      m4_q <= m3_q;
      n4_q <= n3_q;
      z4_q <= z3_q;
      sn_q[0]   <= SQ_W'(q4_q[0]) + SQ_W'(q4_q[1]) + SQ_W'(q4_q[2]);
      sr_q[0]   <= '0;
      sm_q[0]   <= m4_q;
      sneg_q[0] <= n4_q;
      sz_q[0]   <= z4_q;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic [SQ_W-1:0] bt, trial, n_d, r_d;

    always_comb begin
      bt    = SQ_W'(1) << (2 * (ROOT_W - 1 - i));
      trial = sr_q[i] + bt;
      if (sn_q[i] >= trial) begin
        n_d = sn_q[i] - trial;
        r_d = (sr_q[i] >> 1) + bt;
      end else begin
        n_d = sn_q[i];
        r_d = sr_q[i] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[i+1] <= sv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q[i+1]   <= n_d;
        sr_q[i+1]   <= r_d;
        sm_q[i+1]   <= sm_q[i];
        sneg_q[i+1] <= sneg_q[i];
        sz_q[i+1]   <= sz_q[i];
      end
    end
  end

  // divide stages
  logic [ROOT_W-1:0]       dn_q   [QW+1];
  logic [2:0][ROOT_W-1:0]  dr_q   [QW+1];
  logic [2:0][QW-1:0]      dl_q   [QW+1];
  logic [2:0][QW-1:0]      dq_q   [QW+1];
  logic [2:0]              dneg_q [QW+1];
  logic                    dz_q   [QW+1];
  logic                    dv_q   [QW+1];

  logic [ROOT_W-1:0]      nm_d;
  logic [2:0][ROOT_W-1:0] r0_d;
  logic [2:0][QW-1:0]     l0_d;

  always_comb begin
    logic [DW-1:0] dd;
    nm_d = sr_q[ROOT_W][ROOT_W-1:0];
    if (nm_d == '0) nm_d = ROOT_W'(1);
    for (int k = 0; k < 3; k++) begin
      dd      = DW'({sm_q[ROOT_W][k], {OUT_FRAC{1'b0}}}) + DW'(nm_d >> 1);
      r0_d[k] = ROOT_W'(dd[DW-1:QW]);
      l0_d[k] = dd[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn_q[0]   <= nm_d;
      dr_q[0]   <= r0_d;
      dl_q[0]   <= l0_d;
      dq_q[0]   <= '0;
      dneg_q[0] <= sneg_q[ROOT_W];
      dz_q[0]   <= sz_q[ROOT_W];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][ROOT_W-1:0] r_d;
    logic [2:0][QW-1:0]     l_d, q_d;

    always_comb begin
      logic [ROOT_W:0] r2;
      for (int k = 0; k < 3; k++) begin
        r2     = {dr_q[j][k], dl_q[j][k][QW-1]};
        l_d[k] = {dl_q[j][k][QW-2:0], 1'b0};
        if (r2 >= {1'b0, dn_q[j]}) begin
          r_d[k] = ROOT_W'(r2 - {1'b0, dn_q[j]});
          q_d[k] = {dq_q[j][k][QW-2:0], 1'b1};
        end else begin
          r_d[k] = r2[ROOT_W-1:0];
          q_d[k] = {dq_q[j][k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dn_q[j+1]   <= dn_q[j];
        dr_q[j+1]   <= r_d;
        dl_q[j+1]   <= l_d;
        dq_q[j+1]   <= q_d;
        dneg_q[j+1] <= dneg_q[j];
        dz_q[j+1]   <= dz_q[j];
      end
    end
  end

  // sign restore
  logic                     vo_q, zo_q;
  logic [2:0][OUT_FRAC+1:0] ax_d, ax_q;

  always_comb begin
    logic [OUT_FRAC+1:0] mg;
    for (int k = 0; k < 3; k++) begin
      mg      = {1'b0, dq_q[QW][k]};
      ax_d[k] = dneg_q[QW][k] ? (~mg + 1'b1) : mg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= ax_d;
      zo_q <= dz_q[QW];
    end
  end

  assign valid_o = vo_q;
  assign axis_o  = ax_q;
  assign deg_o   = zo_q;

endmodule

[design/tam_triad.sv]
// one triad: cross product, normalization of first and second axes, third axis
module tam_triad #(
  parameter int W        = 16,
  parameter int OUT_FRAC = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][W-1:0]             a_i,
  input  logic [2:0][W-1:0]             b_i,
  output logic                          valid_o,
  output logic [2:0][2:0][OUT_FRAC+1:0] axes_o,
  output logic                          deg_o
);
  import tam_pkg::*;

  localparam int AW  = OUT_FRAC + 2;
  localparam int CW  = 2 * W + 1;
  localparam int EW  = 2 * AW + 1;
  localparam int DLW = 6 * AW + 1;

  // a x b
  logic                   c1v_q, c2v_q;
  logic signed [2*W-1:0]  p_q [6];
  logic [2:0][CW-1:0]     c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1v_q <= 1'b0;
      c2v_q <= 1'b0;
    end else if (en_i) begin
      c1v_q <= valid_i;
      c2v_q <= c1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= $signed(a_i[1]) * $signed(b_i[2]);
      p_q[1] <= $signed(a_i[2]) * $signed(b_i[1]);
      p_q[2] <= $signed(a_i[2]) * $signed(b_i[0]);
      p_q[3] <= $signed(a_i[0]) * $signed(b_i[2]);
      p_q[4] <= $signed(a_i[0]) * $signed(b_i[1]);
      p_q[5] <= $signed(a_i[1]) * $signed(b_i[0]);
      c_q[0] <= CW'(p_q[0]) - CW'(p_q[1]);
      c_q[1] <= CW'(p_q[2]) - CW'(p_q[3]);
      c_q[2] <= CW'(p_q[4]) - CW'(p_q[5]);
    end
  end

  logic [2:0][W-1:0] a_dl;

  tam_delay #(.W(3 * W), .DEPTH(2)) u_dly_a (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (a_i),
    .q_o   (a_dl)
  );

  logic               na_v, nc_v, na_deg, nc_deg;
  logic [2:0][AW-1:0] t1, t2;

  tam_norm #(.VW(W), .OUT_FRAC(OUT_FRAC)) u_norm_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (c2v_q),
    .vec_i   (a_dl),
    .valid_o (na_v),
    .axis_o  (t1),
    .deg_o   (na_deg)
  );

  tam_norm #(.VW(CW), .OUT_FRAC(OUT_FRAC)) u_norm_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (c2v_q),
    .vec_i   (c_q),
    .valid_o (nc_v),
    .axis_o  (t2),
    .deg_o   (nc_deg)
  );

  // t1 x t2
  logic                  e1v_q, e2v_q;
  logic signed [2*AW-1:0] e_q [6];
  logic [2:0][EW-1:0]    f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1v_q <= 1'b0;
      e2v_q <= 1'b0;
    end else if (en_i) begin
      e1v_q <= na_v & nc_v;
      e2v_q <= e1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0] <= $signed(t1[1]) * $signed(t2[2]);
      e_q[1] <= $signed(t1[2]) * $signed(t2[1]);
      e_q[2] <= $signed(t1[2]) * $signed(t2[0]);
      e_q[3] <= $signed(t1[0]) * $signed(t2[2]);
      e_q[4] <= $signed(t1[0]) * $signed(t2[1]);
      e_q[5] <= $signed(t1[1]) * $signed(t2[0]);
      f_q[0] <= EW'(e_q[0]) - EW'(e_q[1]);
      f_q[1] <= EW'(e_q[2]) - EW'(e_q[3]);
      f_q[2] <= EW'(e_q[4]) - EW'(e_q[5]);
    end
  end

  logic [DLW-1:0]     side_dl;
  logic [2:0][AW-1:0] t3;
  logic               n3_deg;

  tam_delay #(.W(DLW), .DEPTH(2 + norm_lat(OUT_FRAC))) u_dly_t (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({na_deg | nc_deg, t2, t1}),
    .q_o   (side_dl)
  );

  tam_norm #(.VW(EW), .OUT_FRAC(OUT_FRAC)) u_norm_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (e2v_q),
    .vec_i   (f_q),
    .valid_o (valid_o),
    .axis_o  (t3),
    .deg_o   (n3_deg)
  );

  assign axes_o[0] = side_dl[3*AW-1:0];
  assign axes_o[1] = side_dl[6*AW-1:3*AW];
  assign axes_o[2] = t3;
  assign deg_o     = side_dl[DLW-1] | n3_deg;

endmodule

[design/tam_matmul.sv]
// rotation matrix: products of measured and reference axes, then round and saturate
module tam_matmul #(
  parameter int OUT_FRAC = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][2:0][OUT_FRAC+1:0] m_i,
  input  logic [2:0][2:0][OUT_FRAC+1:0] v_i,
  input  logic                          deg_i,
  output logic                          valid_o,
  output logic [8:0][tam_pkg::ROT_W-1:0] rot_o,
  output logic                          deg_o
);
  import tam_pkg::*;

  localparam int AW  = OUT_FRAC + 2;
  localparam int PW  = 2 * AW;
  localparam int SMW = PW + 2;

  logic                  v1_q, v2_q, d1_q, d2_q;
  logic signed [PW-1:0]  pr_q [9][3];
  logic [8:0][ROT_W-1:0] rot_d, rot_q;

  always_comb begin
    logic signed [SMW-1:0] acc, r, lim;
    lim = SMW'(1) << OUT_FRAC;
    for (int e = 0; e < 9; e++) begin
      acc = SMW'(pr_q[e][0]) + SMW'(pr_q[e][1]) + SMW'(pr_q[e][2])
          + (SMW'(1) << (OUT_FRAC - 1));
      r = acc >>> OUT_FRAC;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      rot_d[e] = r[ROT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pr_q[i*3+j][k] <= $signed(m_i[k][i]) * $signed(v_i[k][j]);
          end
        end
      end
      d1_q  <= deg_i;
      d2_q  <= d1_q;
      rot_q <= rot_d;
    end
  end

  assign valid_o = v2_q;
  assign rot_o   = rot_q;
  assign deg_o   = d2_q;

endmodule

[design/triad_attitude_matrix.sv]
// triad attitude matrix top level: two triad pipelines, matrix product, output buffer
// path from input beat to output valid: two normalizer levels in series per triad, each set by
//   the bitwise square root and restoring divide stages, then the matrix product and output register
// throughput: one beat per cycle, the pipeline stalls only when the output skid is full
// reset: asynchronous active low, clears all valid bits; payload registers are not reset
module triad_attitude_matrix #(
  parameter int IN_WIDTH = 16,
  parameter int OUT_FRAC = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [IN_WIDTH-1:0] ref_a_x_i,
  input  logic [IN_WIDTH-1:0] ref_a_y_i,
  input  logic [IN_WIDTH-1:0] ref_a_z_i,
  input  logic [IN_WIDTH-1:0] ref_b_x_i,
  input  logic [IN_WIDTH-1:0] ref_b_y_i,
  input  logic [IN_WIDTH-1:0] ref_b_z_i,
  input  logic [IN_WIDTH-1:0] meas_a_x_i,
  input  logic [IN_WIDTH-1:0] meas_a_y_i,
  input  logic [IN_WIDTH-1:0] meas_a_z_i,
  input  logic [IN_WIDTH-1:0] meas_b_x_i,
  input  logic [IN_WIDTH-1:0] meas_b_y_i,
  input  logic [IN_WIDTH-1:0] meas_b_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [tam_pkg::ROT_W-1:0] rot_00_o,
  output logic [tam_pkg::ROT_W-1:0] rot_01_o,
  output logic [tam_pkg::ROT_W-1:0] rot_02_o,
  output logic [tam_pkg::ROT_W-1:0] rot_10_o,
  output logic [tam_pkg::ROT_W-1:0] rot_11_o,
  output logic [tam_pkg::ROT_W-1:0] rot_12_o,
  output logic [tam_pkg::ROT_W-1:0] rot_20_o,
  output logic [tam_pkg::ROT_W-1:0] rot_21_o,
  output logic [tam_pkg::ROT_W-1:0] rot_22_o,
  output logic                degenerate_o
);
  import tam_pkg::*;

  localparam int W  = (IN_WIDTH > IN_LIM) ? IN_LIM : IN_WIDTH;
  localparam int AW = OUT_FRAC + 2;
  localparam int BW = 9 * ROT_W + 1;

  logic en;

  // floor shift of wide inputs is a top slice
  logic [2:0][W-1:0] ra, rb, ma, mb;

  assign ra[0] = ref_a_x_i[IN_WIDTH-1 -: W];
  assign ra[1] = ref_a_y_i[IN_WIDTH-1 -: W];
  assign ra[2] = ref_a_z_i[IN_WIDTH-1 -: W];
  assign rb[0] = ref_b_x_i[IN_WIDTH-1 -: W];
  assign rb[1] = ref_b_y_i[IN_WIDTH-1 -: W];
  assign rb[2] = ref_b_z_i[IN_WIDTH-1 -: W];
  assign ma[0] = meas_a_x_i[IN_WIDTH-1 -: W];
  assign ma[1] = meas_a_y_i[IN_WIDTH-1 -: W];
  assign ma[2] = meas_a_z_i[IN_WIDTH-1 -: W];
  assign mb[0] = meas_b_x_i[IN_WIDTH-1 -: W];
  assign mb[1] = meas_b_y_i[IN_WIDTH-1 -: W];
  assign mb[2] = meas_b_z_i[IN_WIDTH-1 -: W];

  logic                    in_beat;
  logic                    rv, mv, rdeg, mdeg;
  logic [2:0][2:0][AW-1:0] vt, mt;

  assign in_beat = in_valid_i & en;

  tam_triad #(.W(W), .OUT_FRAC(OUT_FRAC)) u_triad_ref (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_beat),
    .a_i     (ra),
    .b_i     (rb),
    .valid_o (rv),
    .axes_o  (vt),
    .deg_o   (rdeg)
  );

  tam_triad #(.W(W), .OUT_FRAC(OUT_FRAC)) u_triad_meas (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_beat),
    .a_i     (ma),
    .b_i     (mb),
    .valid_o (mv),
    .axes_o  (mt),
    .deg_o   (mdeg)
  );

  logic                  pv, pdeg;
  logic [8:0][ROT_W-1:0] prot;

  tam_matmul #(.OUT_FRAC(OUT_FRAC)) u_matmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv & mv),
    .m_i     (mt),
    .v_i     (vt),
    .deg_i   (rdeg | mdeg),
    .valid_o (pv),
    .rot_o   (prot),
    .deg_o   (pdeg)
  );

  // output register plus skid
  logic          ov_q, sv_q;
  logic [BW-1:0] ob_q, sb_q, pbuf;

  assign pbuf = {pdeg, prot};
  assign en   = ~sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && !out_ready_i) begin
      if (pv && en) sv_q <= 1'b1;
    end else if (sv_q) begin
      ov_q <= 1'b1;
      sv_q <= 1'b0;
    end else begin
      ov_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && !out_ready_i) begin
      if (en) sb_q <= pbuf;
    end else if (sv_q) begin
      ob_q <= sb_q;
    end else begin
      ob_q <= pbuf;
    end
  end

  assign in_ready_o   = en;
  assign out_valid_o  = ov_q;
  assign rot_00_o     = ob_q[0*ROT_W +: ROT_W];
  assign rot_01_o     = ob_q[1*ROT_W +: ROT_W];
  assign rot_02_o     = ob_q[2*ROT_W +: ROT_W];
  assign rot_10_o     = ob_q[3*ROT_W +: ROT_W];
  assign rot_11_o     = ob_q[4*ROT_W +: ROT_W];
  assign rot_12_o     = ob_q[5*ROT_W +: ROT_W];
  assign rot_20_o     = ob_q[6*ROT_W +: ROT_W];
  assign rot_21_o     = ob_q[7*ROT_W +: ROT_W];
  assign rot_22_o     = ob_q[8*ROT_W +: ROT_W];
  assign degenerate_o = ob_q[BW-1];

endmodule

[test/triad_attitude_matrix_tb.sv]
// testbench for the triad attitude matrix: random and directed vector sets checked against a predictor
`timescale 1ns / 100ps

module triad_attitude_matrix_tb;

  localparam int IN_WIDTH = 16;
  localparam int OUT_FRAC = 14;
  localparam int ROT_W    = tam_pkg::ROT_W;
  localparam int LATENCY  = 2 * tam_pkg::norm_lat(OUT_FRAC) + 7;
  localparam int STALL_LIMIT = 20 * LATENCY + 2000;

  typedef logic signed [IN_WIDTH-1:0] comp_t;
  typedef struct packed {
    comp_t ra_x, ra_y, ra_z, rb_x, rb_y, rb_z;
    comp_t ma_x, ma_y, ma_z, mb_x, mb_y, mb_z;
  } vec_set_t;
  typedef struct packed {
    logic signed [ROT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic degenerate;
  } attitude_t;
  typedef longint vec3_t [3];

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  vec_set_t cur;
  attitude_t got;

  vec_set_t pending_sets[$];
  attitude_t expected_attitudes[$];
  int errors, sets_sent, attitudes_seen, degenerate_seen, idle_cycles;
  int send_wait, recv_wait, hold_off;
  bit stim_done, hold_req;
  bit in_taken, out_taken;

  triad_attitude_matrix #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC(OUT_FRAC)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .ref_a_x_i(cur.ra_x), .ref_a_y_i(cur.ra_y), .ref_a_z_i(cur.ra_z),
    .ref_b_x_i(cur.rb_x), .ref_b_y_i(cur.rb_y), .ref_b_z_i(cur.rb_z),
    .meas_a_x_i(cur.ma_x), .meas_a_y_i(cur.ma_y), .meas_a_z_i(cur.ma_z),
    .meas_b_x_i(cur.mb_x), .meas_b_y_i(cur.mb_y), .meas_b_z_i(cur.mb_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .rot_00_o(got.r00), .rot_01_o(got.r01), .rot_02_o(got.r02),
    .rot_10_o(got.r10), .rot_11_o(got.r11), .rot_12_o(got.r12),
    .rot_20_o(got.r20), .rot_21_o(got.r21), .rot_22_o(got.r22),
    .degenerate_o(got.degenerate)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint shr_floor(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void cross_prod(input vec3_t p, input vec3_t q, output vec3_t r);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic bit unit_axis(input vec3_t v, output vec3_t u);
    longint unsigned mag[3], top, sq, nrm, q;
    int s;
    top = 0; sq = 0; s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      u = '{0, 0, 0};
      return 1'b1;
    end
    while ((top >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= s;
      sq += mag[i] * mag[i];
    end
    nrm = int_sqrt(sq);
    if (nrm == 0) nrm = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << OUT_FRAC) + (nrm >> 1)) / nrm;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic bit make_triad(input vec3_t a, input vec3_t b, output vec3_t t[3]);
    vec3_t c;
    bit deg;
    deg = unit_axis(a, t[0]);
    cross_prod(a, b, c);
    deg |= unit_axis(c, t[1]);
    cross_prod(t[0], t[1], c);
    deg |= unit_axis(c, t[2]);
    return deg;
  endfunction

  function automatic attitude_t predict_attitude(vec_set_t v);
    vec3_t ra, rb, ma, mb;
    vec3_t vt[3], mt[3];
    longint acc, r, lim;
    logic signed [ROT_W-1:0] m[9];
    attitude_t res;
    ra = '{v.ra_x, v.ra_y, v.ra_z}; rb = '{v.rb_x, v.rb_y, v.rb_z};
    ma = '{v.ma_x, v.ma_y, v.ma_z}; mb = '{v.mb_x, v.mb_y, v.mb_z};
    lim = longint'(1) << OUT_FRAC;
    res.degenerate = make_triad(ra, rb, vt);
    res.degenerate |= make_triad(ma, mb, mt);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += mt[k][i] * vt[k][j];
        r = shr_floor(acc + (longint'(1) << (OUT_FRAC - 1)), OUT_FRAC);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        m[i*3+j] = r[ROT_W-1:0];
      end
    {res.r00, res.r01, res.r02, res.r10, res.r11, res.r12, res.r20, res.r21, res.r22} =
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    return res;
  endfunction

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 64)) - 32;
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return comp_t'($urandom_range(0, 8000)) - 4000;
    endcase
  endfunction

  function automatic vec_set_t rand_set();
    vec_set_t v;
    int mode, kind;
    mode = $urandom_range(0, 3);
    kind = $urandom_range(0, 9);
    {v.ra_x, v.ra_y, v.ra_z} = {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
    {v.rb_x, v.rb_y, v.rb_z} = {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
    {v.ma_x, v.ma_y, v.ma_z} = {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
    {v.mb_x, v.mb_y, v.mb_z} = {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
    // parallel or zero vectors now and then
    if (kind == 0) {v.rb_x, v.rb_y, v.rb_z} = {v.ra_x, v.ra_y, v.ra_z};
    if (kind == 1) {v.mb_x, v.mb_y, v.mb_z} = {-v.ma_x, -v.ma_y, -v.ma_z};
    if (kind == 2) {v.ma_x, v.ma_y, v.ma_z} = '0;
    return v;
  endfunction

  function automatic vec_set_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2, int d0, int d1, int d2);
    vec_set_t v;
    v = {comp_t'(a0), comp_t'(a1), comp_t'(a2), comp_t'(b0), comp_t'(b1), comp_t'(b2),
         comp_t'(c0), comp_t'(c1), comp_t'(c2), comp_t'(d0), comp_t'(d1), comp_t'(d2)};
    return v;
  endfunction

  initial begin
    rst_n = 1'b0;
    stim_done = 1'b0;
    pending_sets.push_back(mk(1, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0));
    pending_sets.push_back(mk(1, 0, 0, 0, 1, 0, 0, 1, 0, -1, 0, 0));
    pending_sets.push_back(mk(0, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9));
    pending_sets.push_back(mk(1, 2, 3, 0, 0, 0, 1, 2, 3, 3, 2, 1));
    pending_sets.push_back(mk(1, 2, 3, 2, 4, 6, 3, 1, 2, -6, -2, -4));
    pending_sets.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_sets.push_back(mk(32767, 32767, 32767, -32768, 32767, -32768,
                              -32768, -32768, -32768, 32767, -32768, 32767));
    pending_sets.push_back(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 32767, 0, 0));
    pending_sets.push_back(mk(32767, -32768, 1, -1, 32767, -32768,
                              -32768, 1, 32767, 32767, 32767, -32768));
    pending_sets.push_back(mk(-1, -1, -1, 1, -1, 1, -1, 1, 1, 1, 1, -1));
    pending_sets.push_back(mk(3, 4, 0, -4, 3, 0, 0, 3, 4, 0, -4, 3));
    pending_sets.push_back(mk(1, 1, 0, 1, 0, 0, -1, -1, 0, 1, 1, 0));
    repeat (600) pending_sets.push_back(rand_set());
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_sets.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  // driver
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cur <= '0;
      send_wait <= 0;
    end else if (in_valid && !in_taken) begin
    end else if (send_wait > 0) begin
      in_valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (pending_sets.size() > 0) begin
      cur <= pending_sets.pop_front();
      in_valid <= 1'b1;
      send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_attitudes.push_back(predict_attitude(cur));
      sets_sent++;
    end
  end

  // receiver, with one long hold-off after the first hundred sets
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      hold_off <= 0;
      hold_req <= 1'b1;
    end else if (hold_req && sets_sent > 100) begin
      hold_req <= 1'b0;
      hold_off <= 3 * LATENCY;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_taken)
        recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
    end
  end

  // monitor
  always @(posedge clk) begin
    attitude_t exp_a;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      attitudes_seen++;
      if (expected_attitudes.size() == 0) begin
        $error("beat with no expected attitude");
        errors++;
      end else begin
        exp_a = expected_attitudes.pop_front();
        if (got.degenerate) degenerate_seen++;
        if (got.r00 !== exp_a.r00) begin $error("rot_00 exp %0d got %0d", exp_a.r00, got.r00); errors++; end
        if (got.r01 !== exp_a.r01) begin $error("rot_01 exp %0d got %0d", exp_a.r01, got.r01); errors++; end
        if (got.r02 !== exp_a.r02) begin $error("rot_02 exp %0d got %0d", exp_a.r02, got.r02); errors++; end
        if (got.r10 !== exp_a.r10) begin $error("rot_10 exp %0d got %0d", exp_a.r10, got.r10); errors++; end
        if (got.r11 !== exp_a.r11) begin $error("rot_11 exp %0d got %0d", exp_a.r11, got.r11); errors++; end
        if (got.r12 !== exp_a.r12) begin $error("rot_12 exp %0d got %0d", exp_a.r12, got.r12); errors++; end
        if (got.r20 !== exp_a.r20) begin $error("rot_20 exp %0d got %0d", exp_a.r20, got.r20); errors++; end
        if (got.r21 !== exp_a.r21) begin $error("rot_21 exp %0d got %0d", exp_a.r21, got.r21); errors++; end
        if (got.r22 !== exp_a.r22) begin $error("rot_22 exp %0d got %0d", exp_a.r22, got.r22); errors++; end
        if (got.degenerate !== exp_a.degenerate) begin
          $error("degenerate exp %0d got %0d", exp_a.degenerate, got.degenerate);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0; sets_sent = 0; attitudes_seen = 0; degenerate_seen = 0; idle_cycles = 0;
    wait (stim_done);
    wait (expected_attitudes.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d vector sets, %0d attitudes checked, %0d degenerate",
             sets_sent, attitudes_seen, degenerate_seen);
    if (errors == 0 && expected_attitudes.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
